// ===== hdl/ut2cal_pkg.sv =====
// Shared constants, reciprocal multipliers and the month table for the
// Unix-time-to-calendar pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ut2cal_pkg;

    // Timestamp width and stream widths
    localparam int TS_W       = 40;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 1;

    localparam logic [TS_W-1:0] LAST_VALID_SEC = TS_W'(64'd253402300799);

    // seconds -> days: ts/86400 = (ts >> 7) / 675, in 17- and 16-bit digits
    localparam int LO_W    = 16;
    localparam int X_W     = TS_W - 7;
    localparam int HI_W    = X_W - LO_W;
    localparam int Q1_W    = HI_W - 9;
    localparam int DAYS_W  = Q1_W + LO_W;
    localparam int R675_W  = 10;
    localparam int Y_W     = R675_W + LO_W;
    localparam int SOD_W   = R675_W + 7;
    localparam int DP3_W   = DAYS_W + 1;
    localparam int WQ_W    = DP3_W - 2;

    // Exact reciprocals: M = ceil(2^K / d) with K = input bits + bits of d
    localparam int K_HI675 = HI_W + R675_W;
    localparam logic [HI_W:0] M_HI675 =
        (HI_W+1)'(((64'd1 << K_HI675) + 64'd674) / 64'd675);
    localparam int K_Y675 = Y_W + R675_W;
    localparam logic [Y_W:0] M_Y675 =
        (Y_W+1)'(((64'd1 << K_Y675) + 64'd674) / 64'd675);
    localparam int K_SOD60 = SOD_W + 6;
    localparam logic [SOD_W:0] M_SOD60 =
        (SOD_W+1)'(((64'd1 << K_SOD60) + 64'd59) / 64'd60);
    localparam int K_MIN60 = 17;
    localparam logic [11:0] M_MIN60 = 12'(((64'd1 << K_MIN60) + 64'd59) / 64'd60);
    localparam int K_WD7 = DP3_W + 3;
    localparam logic [DP3_W:0] M_WD7 =
        (DP3_W+1)'(((64'd1 << K_WD7) + 64'd6) / 64'd7);
    localparam int K_ERA = 40;
    localparam logic [22:0] M_ERA = 23'(((64'd1 << K_ERA) + 64'd146096) / 64'd146097);
    localparam int K_C1460 = 29;
    localparam logic [18:0] M_C1460 = 19'(((64'd1 << K_C1460) + 64'd1459) / 64'd1460);
    localparam int K_C36524 = 34;
    localparam logic [18:0] M_C36524 =
        19'(((64'd1 << K_C36524) + 64'd36523) / 64'd36524);
    localparam int K_Y365 = 27;
    localparam logic [18:0] M_Y365 = 19'(((64'd1 << K_Y365) + 64'd364) / 64'd365);
    localparam int K_YOE100 = 16;
    localparam logic [9:0] M_YOE100 = 10'(((64'd1 << K_YOE100) + 64'd99) / 64'd100);
    localparam int K_MP153 = 19;
    localparam logic [11:0] M_MP153 = 12'(((64'd1 << K_MP153) + 64'd152) / 64'd153);
    localparam int K_DQ5 = 14;
    localparam logic [11:0] M_DQ5 = 12'(((64'd1 << K_DQ5) + 64'd4) / 64'd5);
    localparam int K_YR100 = 21;
    localparam logic [14:0] M_YR100 = 15'(((64'd1 << K_YR100) + 64'd99) / 64'd100);
    localparam int K_WK7 = 12;
    localparam logic [9:0] M_WK7 = 10'(((64'd1 << K_WK7) + 64'd6) / 64'd7);

    // Civil epoch shift: days from 0000-03-01 to 1970-01-01
    localparam logic [21:0] EPOCH_SHIFT = 22'd719468;
    localparam logic [17:0] ERA_LAST_DAY = 18'd146096;

    // Result field positions in tdata, lowest first
    localparam int F_YEAR_LO = 0;
    localparam int F_MON_LO  = 14;
    localparam int F_DAY_LO  = 18;
    localparam int F_HR_LO   = 23;
    localparam int F_MIN_LO  = 28;
    localparam int F_SEC_LO  = 34;
    localparam int F_WD_LO   = 40;
    localparam int F_ORD_LO  = 43;
    localparam int F_WK_LO   = 52;
    localparam int F_END     = 58;

    function automatic logic [8:0] days_before_month(input logic [3:0] mon);
        logic [8:0] r;
        unique case (mon)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/unix_time_to_calendar.sv =====
// Unix timestamp to Gregorian date / time of day, one request per clock.
// A request passes 19 register stages from input handshake to m_axis_tvalid.
// Throughput: one timestamp per cycle; a stall holds full stages, bubbles collapse.
// Reset: aresetn synchronous active low; clears only the stage valid bits.
// Depends on ut2cal_pkg.
`timescale 1ns / 1ps
`default_nettype none

module unix_time_to_calendar
    import ut2cal_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [39:0] epoch_seconds
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [13:0] cal_year, [17:14] cal_month, [22:18] cal_day, [27:23] hour_of_day,
    // [33:28] minute_of_hour, [39:34] second_of_minute, [42:40] iso_weekday,
    // [51:43] ordinal_day, [57:52] simple_week, [63:58] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic [OUT_USER_W-1:0]      m_axis_tuser    // [0] out_of_range
);

    localparam int N_STG = 19;

    // ------------------------------------------------------------------
    // Stage payloads. Stages multiply by constants or by constant reciprocals
    // and add or compare, often more than one per stage. Divisions by constants
    // use exact ceil reciprocals, so no correction step is needed.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] weekday;
    } tod_t;

    typedef struct packed {
        logic            oor;
        logic [6:0]      lo7;
        logic [LO_W-1:0] mid;
        logic [HI_W-1:0] hi;
        logic [Q1_W-1:0] q1;
    } s0_t;

    typedef struct packed {
        logic              oor;
        logic [6:0]        lo7;
        logic [LO_W-1:0]   mid;
        logic [Q1_W-1:0]   q1;
        logic [R675_W-1:0] r1;
    } s1_t;

    typedef struct packed {
        logic            oor;
        logic [6:0]      lo7;
        logic [Q1_W-1:0] q1;
        logic [Y_W-1:0]  y;
        logic [LO_W-1:0] q2;
    } s2_t;

    typedef struct packed {
        logic              oor;
        logic [DAYS_W-1:0] days;
        logic [SOD_W-1:0]  sod;
    } s3_t;

    typedef struct packed {
        logic             oor;
        logic [SOD_W-1:0] sod;
        logic [10:0]      s1;
        logic [DP3_W-1:0] dp3;
        logic [21:0]      z;
    } s4_t;

    typedef struct packed {
        logic             oor;
        logic [5:0]       sec;
        logic [10:0]      s1;
        logic [4:0]       hr;
        logic [DP3_W-1:0] dp3;
        logic [WQ_W-1:0]  wq;
        logic [21:0]      z;
        logic [4:0]       era;
    } s5_t;

    typedef struct packed {
        logic        oor;
        tod_t        tod;
        logic [4:0]  era;
        logic [17:0] doe;
    } s6_t;

    typedef struct packed {
        logic        oor;
        tod_t        tod;
        logic [4:0]  era;
        logic [17:0] doe;
        logic [7:0]  a;
        logic [2:0]  b;
        logic        c;
    } s7_t;

    typedef struct packed {
        logic        oor;
        tod_t        tod;
        logic [4:0]  era;
        logic [17:0] doe;
        logic [17:0] t;
    } s8_t;

    typedef struct packed {
        logic        oor;
        tod_t        tod;
        logic [4:0]  era;
        logic [17:0] doe;
        logic [8:0]  yoe;
    } s9_t;

    typedef struct packed {
        logic        oor;
        tod_t        tod;
        logic [4:0]  era;
        logic [17:0] doe;
        logic [8:0]  yoe;
        logic [17:0] ys;
        logic [2:0]  yq;
    } s10_t;

    typedef struct packed {
        logic       oor;
        tod_t       tod;
        logic [4:0] era;
        logic [8:0] yoe;
        logic [8:0] doy;
    } s11_t;

    typedef struct packed {
        logic       oor;
        tod_t       tod;
        logic [4:0] era;
        logic [8:0] yoe;
        logic [8:0] doy;
        logic [3:0] mp;
    } s12_t;

    typedef struct packed {
        logic       oor;
        tod_t       tod;
        logic [4:0] era;
        logic [8:0] yoe;
        logic [8:0] doy;
        logic [8:0] dq;
        logic [3:0] mon;
    } s13_t;

    typedef struct packed {
        logic        oor;
        tod_t        tod;
        logic [3:0]  mon;
        logic [4:0]  day;
        logic [13:0] year;
    } s14_t;

    typedef struct packed {
        logic        oor;
        tod_t        tod;
        logic [3:0]  mon;
        logic [4:0]  day;
        logic [13:0] year;
        logic [6:0]  cq;
    } s15_t;

    typedef struct packed {
        logic        oor;
        tod_t        tod;
        logic [3:0]  mon;
        logic [4:0]  day;
        logic [13:0] year;
        logic        leap;
    } s16_t;

    typedef struct packed {
        logic        oor;
        tod_t        tod;
        logic [3:0]  mon;
        logic [4:0]  day;
        logic [13:0] year;
        logic [8:0]  ord;
    } s17_t;

    typedef struct packed {
        logic                  oor;
        logic [OUT_DATA_W-1:0] data;
    } s18_t;

    s0_t  st0_reg,  st0_next;
    s1_t  st1_reg,  st1_next;
    s2_t  st2_reg,  st2_next;
    s3_t  st3_reg,  st3_next;
    s4_t  st4_reg,  st4_next;
    s5_t  st5_reg,  st5_next;
    s6_t  st6_reg,  st6_next;
    s7_t  st7_reg,  st7_next;
    s8_t  st8_reg,  st8_next;
    s9_t  st9_reg,  st9_next;
    s10_t st10_reg, st10_next;
    s11_t st11_reg, st11_next;
    s12_t st12_reg, st12_next;
    s13_t st13_reg, st13_next;
    s14_t st14_reg, st14_next;
    s15_t st15_reg, st15_next;
    s16_t st16_reg, st16_next;
    s17_t st17_reg, st17_next;
    s18_t st18_reg, st18_next;

    logic [N_STG-1:0] vld_reg, vld_next;
    logic [N_STG-1:0] ld;

    // ------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its successor loads.
    // The output stage frees itself when the consumer takes the request.
    // ------------------------------------------------------------------
    always_comb begin
        ld[N_STG-1] = ~vld_reg[N_STG-1] | m_axis_tready;
        for (int k = N_STG - 2; k >= 0; k--) begin
            ld[k] = ~vld_reg[k] | ld[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < N_STG; k++) begin
            if (ld[k]) begin
                vld_next[k] = (k == 0) ? s_axis_tvalid : vld_reg[(k == 0) ? 0 : k - 1];
            end else begin
                vld_next[k] = vld_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_axis_tready = ld[0];
    assign m_axis_tvalid = vld_reg[N_STG-1];
    assign m_axis_tdata  = st18_reg.data;
    assign m_axis_tuser  = st18_reg.oor;

    // ------------------------------------------------------------------
    // Stage 0: range check, split ts>>7 into a high digit and a 16-bit
    // low digit, divide the high digit by 675.
    // ------------------------------------------------------------------
    logic [TS_W-1:0]     ts;
    logic [2*HI_W:0]     p_hi675;

    always_comb begin
        ts       = s_axis_tdata[TS_W-1:0];
        p_hi675  = (2*HI_W+1)'(ts[TS_W-1:7+LO_W]) * (2*HI_W+1)'(M_HI675);
        st0_next.oor = ts > LAST_VALID_SEC;
        st0_next.lo7 = ts[6:0];
        st0_next.mid = ts[7+LO_W-1:7];
        st0_next.hi  = ts[TS_W-1:7+LO_W];
        st0_next.q1  = p_hi675[K_HI675+Q1_W-1:K_HI675];
    end

    // Stage 1: remainder of the high digit
    always_comb begin
        st1_next.oor = st0_reg.oor;
        st1_next.lo7 = st0_reg.lo7;
        st1_next.mid = st0_reg.mid;
        st1_next.q1  = st0_reg.q1;
        st1_next.r1  = R675_W'(st0_reg.hi - HI_W'(st0_reg.q1) * HI_W'(675));
    end

    // Stage 2: divide remainder:low digit by 675
    logic [Y_W-1:0] y2;
    logic [2*Y_W:0] p_y675;

    always_comb begin
        y2     = {st1_reg.r1, st1_reg.mid};
        p_y675 = (2*Y_W+1)'(y2) * (2*Y_W+1)'(M_Y675);
        st2_next.oor = st1_reg.oor;
        st2_next.lo7 = st1_reg.lo7;
        st2_next.q1  = st1_reg.q1;
        st2_next.y   = y2;
        st2_next.q2  = p_y675[K_Y675+LO_W-1:K_Y675];
    end

    // Stage 3: day count and seconds of day
    logic [R675_W-1:0] r2;

    always_comb begin
        r2 = R675_W'(st2_reg.y - Y_W'(st2_reg.q2) * Y_W'(675));
        st3_next.oor  = st2_reg.oor;
        st3_next.days = {st2_reg.q1, st2_reg.q2};
        st3_next.sod  = {r2, st2_reg.lo7};
    end

    // Stage 4: minutes of day; weekday and civil day offsets
    logic [2*SOD_W+1:0] p_sod60;

    always_comb begin
        p_sod60 = (2*SOD_W+2)'(st3_reg.sod) * (2*SOD_W+2)'(M_SOD60);
        st4_next.oor = st3_reg.oor;
        st4_next.sod = st3_reg.sod;
        st4_next.s1  = p_sod60[K_SOD60+10:K_SOD60];
        st4_next.dp3 = DP3_W'(st3_reg.days) + DP3_W'(3);
        st4_next.z   = 22'(st3_reg.days) + EPOCH_SHIFT;
    end

    // Stage 5: seconds, hours, days/7 and 400-year era
    logic [22:0]        p_min60;
    logic [2*DP3_W+1:0] p_wd7;
    logic [44:0]        p_era;

    always_comb begin
        p_min60 = 23'(st4_reg.s1) * 23'(M_MIN60);
        p_wd7   = (2*DP3_W+2)'(st4_reg.dp3) * (2*DP3_W+2)'(M_WD7);
        p_era   = 45'(st4_reg.z) * 45'(M_ERA);
        st5_next.oor = st4_reg.oor;
        st5_next.sec = 6'(st4_reg.sod - SOD_W'(st4_reg.s1) * SOD_W'(60));
        st5_next.s1  = st4_reg.s1;
        st5_next.hr  = p_min60[K_MIN60+4:K_MIN60];
        st5_next.dp3 = st4_reg.dp3;
        st5_next.wq  = p_wd7[K_WD7+WQ_W-1:K_WD7];
        st5_next.z   = st4_reg.z;
        st5_next.era = p_era[K_ERA+4:K_ERA];
    end

    // Stage 6: minutes, ISO weekday, day of era
    always_comb begin
        st6_next.oor         = st5_reg.oor;
        st6_next.tod.hour    = st5_reg.hr;
        st6_next.tod.minute  = 6'(st5_reg.s1 - 11'(st5_reg.hr) * 11'd60);
        st6_next.tod.second  = st5_reg.sec;
        st6_next.tod.weekday = 3'(st5_reg.dp3 - DP3_W'(st5_reg.wq) * DP3_W'(7)) + 3'd1;
        st6_next.era         = st5_reg.era;
        st6_next.doe         = 18'(st5_reg.z - 22'(27'(st5_reg.era) * 27'd146097));
    end

    // Stage 7: leap-cycle corrections within the era
    logic [36:0] p_c1460;
    logic [36:0] p_c36524;

    always_comb begin
        p_c1460  = 37'(st6_reg.doe) * 37'(M_C1460);
        p_c36524 = 37'(st6_reg.doe) * 37'(M_C36524);
        st7_next.oor = st6_reg.oor;
        st7_next.tod = st6_reg.tod;
        st7_next.era = st6_reg.era;
        st7_next.doe = st6_reg.doe;
        st7_next.a   = p_c1460[K_C1460+7:K_C1460];
        st7_next.b   = p_c36524[K_C36524+2:K_C36524];
        st7_next.c   = st6_reg.doe == ERA_LAST_DAY;
    end

    // Stage 8
    always_comb begin
        st8_next.oor = st7_reg.oor;
        st8_next.tod = st7_reg.tod;
        st8_next.era = st7_reg.era;
        st8_next.doe = st7_reg.doe;
        st8_next.t   = st7_reg.doe - 18'(st7_reg.a) + 18'(st7_reg.b) - 18'(st7_reg.c);
    end

    // Stage 9: year of era
    logic [36:0] p_y365;

    always_comb begin
        p_y365 = 37'(st8_reg.t) * 37'(M_Y365);
        st9_next.oor = st8_reg.oor;
        st9_next.tod = st8_reg.tod;
        st9_next.era = st8_reg.era;
        st9_next.doe = st8_reg.doe;
        st9_next.yoe = p_y365[K_Y365+8:K_Y365];
    end

    // Stage 10: days before that year within the era
    logic [18:0] p_yoe100;

    always_comb begin
        p_yoe100 = 19'(st9_reg.yoe) * 19'(M_YOE100);
        st10_next.oor = st9_reg.oor;
        st10_next.tod = st9_reg.tod;
        st10_next.era = st9_reg.era;
        st10_next.doe = st9_reg.doe;
        st10_next.yoe = st9_reg.yoe;
        st10_next.ys  = 18'(st9_reg.yoe) * 18'd365;
        st10_next.yq  = p_yoe100[K_YOE100+2:K_YOE100];
    end

    // Stage 11: day of the March-based year
    always_comb begin
        st11_next.oor = st10_reg.oor;
        st11_next.tod = st10_reg.tod;
        st11_next.era = st10_reg.era;
        st11_next.yoe = st10_reg.yoe;
        st11_next.doy = 9'(st10_reg.doe -
                           (st10_reg.ys + 18'(st10_reg.yoe[8:2]) - 18'(st10_reg.yq)));
    end

    // Stage 12: March-based month index
    logic [10:0] x5;
    logic [22:0] p_mp153;

    always_comb begin
        x5      = 11'(st11_reg.doy) * 11'd5 + 11'd2;
        p_mp153 = 23'(x5) * 23'(M_MP153);
        st12_next.oor = st11_reg.oor;
        st12_next.tod = st11_reg.tod;
        st12_next.era = st11_reg.era;
        st12_next.yoe = st11_reg.yoe;
        st12_next.doy = st11_reg.doy;
        st12_next.mp  = p_mp153[K_MP153+3:K_MP153];
    end

    // Stage 13: days before the month, calendar month
    logic [10:0] x153;
    logic [22:0] p_dq5;

    always_comb begin
        x153  = 11'(st12_reg.mp) * 11'd153 + 11'd2;
        p_dq5 = 23'(x153) * 23'(M_DQ5);
        st13_next.oor = st12_reg.oor;
        st13_next.tod = st12_reg.tod;
        st13_next.era = st12_reg.era;
        st13_next.yoe = st12_reg.yoe;
        st13_next.doy = st12_reg.doy;
        st13_next.dq  = p_dq5[K_DQ5+8:K_DQ5];
        st13_next.mon = (st12_reg.mp < 4'd10) ? st12_reg.mp + 4'd3 : st12_reg.mp - 4'd9;
    end

    // Stage 14: day of month and year; January and February belong to next year
    always_comb begin
        st14_next.oor  = st13_reg.oor;
        st14_next.tod  = st13_reg.tod;
        st14_next.mon  = st13_reg.mon;
        st14_next.day  = 5'(st13_reg.doy - st13_reg.dq + 9'd1);
        st14_next.year = 14'(st13_reg.yoe) + 14'(st13_reg.era) * 14'd400 +
                         14'(st13_reg.mon <= 4'd2);
    end

    // Stage 15: century of the year
    logic [28:0] p_yr100;

    always_comb begin
        p_yr100 = 29'(st14_reg.year) * 29'(M_YR100);
        st15_next.oor  = st14_reg.oor;
        st15_next.tod  = st14_reg.tod;
        st15_next.mon  = st14_reg.mon;
        st15_next.day  = st14_reg.day;
        st15_next.year = st14_reg.year;
        st15_next.cq   = p_yr100[K_YR100+6:K_YR100];
    end

    // Stage 16: leap year; divisible by 400 means century divisible by 4
    logic [6:0] yr_rem;

    always_comb begin
        yr_rem = 7'(st15_reg.year - 14'(st15_reg.cq) * 14'd100);
        st16_next.oor  = st15_reg.oor;
        st16_next.tod  = st15_reg.tod;
        st16_next.mon  = st15_reg.mon;
        st16_next.day  = st15_reg.day;
        st16_next.year = st15_reg.year;
        st16_next.leap = ((yr_rem != 7'd0) && (st15_reg.year[1:0] == 2'd0)) ||
                         ((yr_rem == 7'd0) && (st15_reg.cq[1:0] == 2'd0));
    end

    // Stage 17: ordinal day
    always_comb begin
        st17_next.oor  = st16_reg.oor;
        st17_next.tod  = st16_reg.tod;
        st17_next.mon  = st16_reg.mon;
        st17_next.day  = st16_reg.day;
        st17_next.year = st16_reg.year;
        st17_next.ord  = days_before_month(st16_reg.mon) + 9'(st16_reg.day) +
                         9'((st16_reg.mon > 4'd2) && st16_reg.leap);
    end

    // Stage 18: week number, blank the date fields when out of range, pack
    logic [8:0]  ord6;
    logic [18:0] p_wk7;
    logic [5:0]  week;

    always_comb begin
        ord6  = st17_reg.ord + 9'd6;
        p_wk7 = 19'(ord6) * 19'(M_WK7);
        week  = p_wk7[K_WK7+5:K_WK7];
        st18_next.oor  = st17_reg.oor;
        st18_next.data = '0;
        st18_next.data[F_HR_LO  +: 5] = st17_reg.tod.hour;
        st18_next.data[F_MIN_LO +: 6] = st17_reg.tod.minute;
        st18_next.data[F_SEC_LO +: 6] = st17_reg.tod.second;
        if (!st17_reg.oor) begin
            st18_next.data[F_YEAR_LO +: 14] = st17_reg.year;
            st18_next.data[F_MON_LO  +: 4]  = st17_reg.mon;
            st18_next.data[F_DAY_LO  +: 5]  = st17_reg.day;
            st18_next.data[F_WD_LO   +: 3]  = st17_reg.tod.weekday;
            st18_next.data[F_ORD_LO  +: 9]  = st17_reg.ord;
            st18_next.data[F_WK_LO   +: 6]  = week;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            st0_reg <= st0_next;
        end
        if (ld[1]) begin
            st1_reg <= st1_next;
        end
        if (ld[2]) begin
            st2_reg <= st2_next;
        end
        if (ld[3]) begin
            st3_reg <= st3_next;
        end
        if (ld[4]) begin
            st4_reg <= st4_next;
        end
        if (ld[5]) begin
            st5_reg <= st5_next;
        end
        if (ld[6]) begin
            st6_reg <= st6_next;
        end
        if (ld[7]) begin
            st7_reg <= st7_next;
        end
        if (ld[8]) begin
            st8_reg <= st8_next;
        end
        if (ld[9]) begin
            st9_reg <= st9_next;
        end
        if (ld[10]) begin
            st10_reg <= st10_next;
        end
        if (ld[11]) begin
            st11_reg <= st11_next;
        end
        if (ld[12]) begin
            st12_reg <= st12_next;
        end
        if (ld[13]) begin
            st13_reg <= st13_next;
        end
        if (ld[14]) begin
            st14_reg <= st14_next;
        end
        if (ld[15]) begin
            st15_reg <= st15_next;
        end
        if (ld[16]) begin
            st16_reg <= st16_next;
        end
        if (ld[17]) begin
            st17_reg <= st17_next;
        end
        if (ld[18]) begin
            st18_reg <= st18_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ut2cal_chk.sv =====
// Port-level checker for unix_time_to_calendar and its bind.
// Depends on ut2cal_pkg for the result field layout.
`timescale 1ns / 1ps
`default_nettype none

module ut2cal_chk
    import ut2cal_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [OUT_USER_W-1:0] m_axis_tuser
);

    logic [3:0] mon;
    logic [4:0] day;
    logic [4:0] hr;
    logic [5:0] mnt;
    logic [5:0] sec;
    logic [2:0] wd;
    logic [8:0] ord;
    logic [5:0] wk;

    assign mon = m_axis_tdata[F_MON_LO +: 4];
    assign day = m_axis_tdata[F_DAY_LO +: 5];
    assign hr  = m_axis_tdata[F_HR_LO  +: 5];
    assign mnt = m_axis_tdata[F_MIN_LO +: 6];
    assign sec = m_axis_tdata[F_SEC_LO +: 6];
    assign wd  = m_axis_tdata[F_WD_LO  +: 3];
    assign ord = m_axis_tdata[F_ORD_LO +: 9];
    assign wk  = m_axis_tdata[F_WK_LO  +: 6];

    // a held request keeps its contents
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // out-of-range requests carry no date
    a_oor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[F_DAY_LO+4:0] == '0 && wd == 3'd0 && ord == 9'd0 && wk == 6'd0)
        else $error("date fields set on out-of-range request");

    // in-range date fields stay legal
    a_date: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |->
            mon >= 4'd1 && mon <= 4'd12 && day >= 5'd1 && wd >= 3'd1 &&
            ord >= 9'd1 && ord <= 9'd366 && wk >= 6'd1 && wk <= 6'd53)
        else $error("date field out of bounds");

    // time of day is always legal
    a_tod: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> hr <= 5'd23 && mnt <= 6'd59 && sec <= 6'd59)
        else $error("time of day out of bounds");

endmodule

bind unix_time_to_calendar ut2cal_chk u_ut2cal_chk (.*);

`default_nettype wire

// ===== bench/civil_date_checker.sv =====
// Checker for unix_time_to_calendar: watches both stream channels, predicts
// the civil date of every accepted timestamp and compares results in order.
// Depends on ut2cal_pkg for stream widths and result field positions.
`timescale 1ns / 1ps

module civil_date_checker
    import ut2cal_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic [OUT_USER_W-1:0] m_axis_tuser,
    output int                    fail_count,
    output int                    pending_dates
);

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
        logic [8:0]  ordinal;
        logic [5:0]  week;
        logic        out_of_range;
    } civil_date_t;

    localparam longint unsigned SECONDS_PER_DAY  = 86400;
    localparam longint unsigned SECONDS_PER_HOUR = 3600;
    localparam longint unsigned DATE_LIMIT_SEC   = 64'd253402300799;
    localparam longint unsigned DAYS_TO_EPOCH    = 719468;   // 0000-03-01 .. 1970-01-01
    localparam longint unsigned DAYS_PER_ERA     = 146097;
    localparam int unsigned MONTH_START [12] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    civil_date_t expected_dates [$];

    function automatic civil_date_t civil_date_of(input logic [IN_DATA_W-1:0] stamp);
        longint unsigned secs, sod, days, shifted, era, doe, yoe, doy, mp;
        longint unsigned d, m, y, ord;
        civil_date_t r;
        secs = stamp;
        sod  = secs % SECONDS_PER_DAY;
        days = secs / SECONDS_PER_DAY;
        r = '0;
        r.hour   = 5'(sod / SECONDS_PER_HOUR);
        r.minute = 6'((sod / 60) % 60);
        r.second = 6'(sod % 60);
        if (secs > DATE_LIMIT_SEC) begin
            r.out_of_range = 1'b1;
        end else begin
            // March-based years in 400-year eras
            shifted = days + DAYS_TO_EPOCH;
            era = shifted / DAYS_PER_ERA;
            doe = shifted - era * DAYS_PER_ERA;
            yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp  = (5 * doy + 2) / 153;
            d   = doy - (153 * mp + 2) / 5 + 1;
            m   = (mp < 10) ? mp + 3 : mp - 9;
            y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
            ord = MONTH_START[m - 1] + d;
            if (m > 2 && ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0))
                ord = ord + 1;
            r.year    = 14'(y);
            r.month   = 4'(m);
            r.day     = 5'(d);
            r.ordinal = 9'(ord);
            r.week    = 6'((ord + 6) / 7);
            r.weekday = 3'((days + 3) % 7 + 1);   // epoch day was a Thursday
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
        fail_count = fail_count + 1;
    endtask

    always @(posedge aclk) begin : watch
        civil_date_t want, got;
        if (!aresetn) begin
            expected_dates.delete();
            pending_dates <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_dates.push_back(civil_date_of(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_dates.size() == 0) begin
                    report_mismatch("result with no request pending", 0, m_axis_tdata);
                end else begin
                    want = expected_dates.pop_front();
                    got.year         = m_axis_tdata[F_YEAR_LO +: 14];
                    got.month        = m_axis_tdata[F_MON_LO  +: 4];
                    got.day          = m_axis_tdata[F_DAY_LO  +: 5];
                    got.hour         = m_axis_tdata[F_HR_LO   +: 5];
                    got.minute       = m_axis_tdata[F_MIN_LO  +: 6];
                    got.second       = m_axis_tdata[F_SEC_LO  +: 6];
                    got.weekday      = m_axis_tdata[F_WD_LO   +: 3];
                    got.ordinal      = m_axis_tdata[F_ORD_LO  +: 9];
                    got.week         = m_axis_tdata[F_WK_LO   +: 6];
                    got.out_of_range = m_axis_tuser[0];
                    if (got.year !== want.year)
                        report_mismatch("cal_year", want.year, got.year);
                    if (got.month !== want.month)
                        report_mismatch("cal_month", want.month, got.month);
                    if (got.day !== want.day)
                        report_mismatch("cal_day", want.day, got.day);
                    if (got.hour !== want.hour)
                        report_mismatch("hour_of_day", want.hour, got.hour);
                    if (got.minute !== want.minute)
                        report_mismatch("minute_of_hour", want.minute, got.minute);
                    if (got.second !== want.second)
                        report_mismatch("second_of_minute", want.second, got.second);
                    if (got.weekday !== want.weekday)
                        report_mismatch("iso_weekday", want.weekday, got.weekday);
                    if (got.ordinal !== want.ordinal)
                        report_mismatch("ordinal_day", want.ordinal, got.ordinal);
                    if (got.week !== want.week)
                        report_mismatch("simple_week", want.week, got.week);
                    if (got.out_of_range !== want.out_of_range)
                        report_mismatch("out_of_range", want.out_of_range,
                                        got.out_of_range);
                end
            end
            pending_dates <= expected_dates.size();
        end
    end

endmodule

// ===== bench/unix_time_to_calendar_test.sv =====
// Top of the unix_time_to_calendar bench: clock, reset, timestamp stimulus,
// random back-pressure and the verdict. Depends on ut2cal_pkg, the block and
// civil_date_checker.
`timescale 1ns / 1ps

module unix_time_to_calendar_test;
    import ut2cal_pkg::*;

    // Last second of 9999-12-31 and the day number of 9999-12-31
    localparam logic [39:0]     DATE_LIMIT_SEC = 40'd253402300799;
    localparam longint          LAST_DAY       = 2932896;
    localparam int              RANDOM_STAMPS  = 550;
    localparam int              IDLE_PERCENT   = 16;
    localparam int              DRAIN_CYCLES   = 40;    // more than the pipeline depth

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    int   fail_count;
    int   pending_dates;
    logic steady_flow = 1'b0;   // high: neither side idles

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    unix_time_to_calendar u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),     // [39:0] epoch_seconds
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),     // [13:0] year .. [57:52] simple_week
        .m_axis_tuser  (m_axis_tuser)      // [0] out_of_range
    );

    civil_date_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending_dates (pending_dates)
    );

    // Receiver: drops tready on about 16 percent of clocks unless the flow is steady.
    always @(posedge aclk)
        m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);

    // Random timestamp. Most land inside the calendar range; a good share sits
    // on year starts and the end of February, where leap rules and week 53
    // show up; the rest is the range limit, overflow and raw bit patterns.
    function automatic logic [39:0] random_stamp();
        int          pick;
        logic [63:0] raw;
        longint      yr, days, sod;
        pick = $urandom_range(0, 99);
        raw  = {$urandom(), $urandom()};
        if (pick < 45)
            return 40'(raw % (64'(DATE_LIMIT_SEC) + 1));
        if (pick < 65) begin
            // rough day count of Jan 1 of a random year, jittered a few days
            yr   = $urandom_range(1970, 9999);
            days = ((yr - 1970) * 146097) / 400;
            if ($urandom_range(0, 1))
                days = days + 59;                   // around Feb 29 / Mar 1
            days = days + $urandom_range(0, 4) - 2;
            if (days < 0)
                days = 0;
            if (days > LAST_DAY)
                days = LAST_DAY;
            case ($urandom_range(0, 2))
                0:       sod = 0;
                1:       sod = 86399;
                default: sod = $urandom_range(0, 86399);
            endcase
            return 40'(days * 86400 + sod);
        end
        if (pick < 75)
            return DATE_LIMIT_SEC - 200 + 40'($urandom_range(0, 400));
        if (pick < 88)
            return DATE_LIMIT_SEC + 1 + 40'(raw % (64'(40'hFF_FFFF_FFFF - DATE_LIMIT_SEC)));
        return raw[39:0];
    endfunction

    // Presents one timestamp, sometimes after a one-cycle gap, and holds it until
    // the request is taken. tvalid stays high afterwards for back-to-back sends.
    task automatic send_stamp(input logic [39:0] stamp);
        if (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= stamp;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Sender lowers tvalid and waits for the pipeline to empty.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_dates != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        logic [39:0] corner_stamps [$];
        corner_stamps = '{
            40'd0,                  // epoch, Thursday
            40'd59, 40'd3599,       // minute and hour rollover edges
            40'd86399, 40'd86400,   // day boundary
            40'd259200,             // first Sunday
            40'd345600,             // first Monday
            40'd94694399,           // 1972-12-31: day 366, week 53
            40'd951782400,          // 2000-02-29, leap century
            40'd951868800,          // 2000-03-01
            40'd978307199,          // last second of 2000
            40'd4107542400,         // 2100-03-01, century without leap day
            40'd2147483647, 40'd2147483648,
            40'd4294967295, 40'd4294967296,
            40'd253402214400,       // 9999-12-31 midnight
            DATE_LIMIT_SEC,         // last second in range
            DATE_LIMIT_SEC + 1,     // first second past the range
            40'h80_0000_0000,
            40'h55_5555_5555, 40'hAA_AAAA_AAAA,
            40'hFF_FFFF_FFFF        // all ones
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (corner_stamps[i])
            send_stamp(corner_stamps[i]);

        // hold off until every corner result is back
        wait_for_drain();

        for (int n = 0; n < RANDOM_STAMPS; n++) begin
            // one long stretch with both sides running flat out
            if (n == 200)
                steady_flow <= 1'b1;
            if (n == 350)
                steady_flow <= 1'b0;
            send_stamp(random_stamp());
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_dates == 0)
            $display("unix_time_to_calendar verification clean");
        else
            $display("unix_time_to_calendar verification failed");
        $finish;
    end

    // Hard stop: 2 ms, far beyond a slow but correct run of about 600 requests.
    initial begin : watchdog
        #2_000_000;
        $display("unix_time_to_calendar verification failed");
        $finish;
    end

endmodule
